>>> src/pst_pkg.sv
// Package for the Pascal source tokenizer: result and push types, scan modes,
// token kinds, error codes and the keyword table with its match function.
// No dependencies.
package pst_pkg;

   localparam int RESULT_BITS = 24;

   // symbol kinds
   localparam logic [5:0] SYM_PLUS   = 6'd0;
   localparam logic [5:0] SYM_MINUS  = 6'd1;
   localparam logic [5:0] SYM_STAR   = 6'd2;
   localparam logic [5:0] SYM_SLASH  = 6'd3;
   localparam logic [5:0] SYM_EQ     = 6'd4;
   localparam logic [5:0] SYM_LT     = 6'd5;
   localparam logic [5:0] SYM_GT     = 6'd6;
   localparam logic [5:0] SYM_LBRK   = 6'd7;
   localparam logic [5:0] SYM_RBRK   = 6'd8;
   localparam logic [5:0] SYM_DOT    = 6'd9;
   localparam logic [5:0] SYM_COMMA  = 6'd10;
   localparam logic [5:0] SYM_COLON  = 6'd11;
   localparam logic [5:0] SYM_SEMI   = 6'd12;
   localparam logic [5:0] SYM_ARROW  = 6'd13;
   localparam logic [5:0] SYM_LPAR   = 6'd14;
   localparam logic [5:0] SYM_RPAR   = 6'd15;
   localparam logic [5:0] SYM_NE     = 6'd16;
   localparam logic [5:0] SYM_LE     = 6'd17;
   localparam logic [5:0] SYM_GE     = 6'd18;
   localparam logic [5:0] SYM_ASSIGN = 6'd19;
   localparam logic [5:0] SYM_DOTDOT = 6'd20;

   localparam logic [5:0] KIND_FIRST_KW = 6'd21;
   localparam logic [5:0] KIND_IDENT    = 6'd56;
   localparam logic [5:0] KIND_INT      = 6'd57;
   localparam logic [5:0] KIND_REAL     = 6'd58;
   localparam logic [5:0] KIND_CHAR     = 6'd59;
   localparam logic [5:0] KIND_STRING   = 6'd60;
   localparam logic [5:0] KIND_EOF      = 6'd61;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NON_ASCII = 3'd1;
   localparam logic [2:0] ERR_OPEN_CMT  = 3'd2;
   localparam logic [2:0] ERR_BAD_START = 3'd3;
   localparam logic [2:0] ERR_DIGIT     = 3'd4;
   localparam logic [2:0] ERR_STR_CHAR  = 3'd5;
   localparam logic [2:0] ERR_NO_SEP    = 3'd6;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd7;

   localparam logic [4:0] DIGIT_CODE = 5'd27;
   localparam int         WORD_DEPTH = 9;
   localparam int         KW_COUNT   = 35;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_COMMENT, MODE_COMMENT_STAR, MODE_HELD, MODE_INT_U, MODE_INT_S,
      MODE_DOT_U, MODE_DOT_S, MODE_FRAC, MODE_EXP_START, MODE_EXP_SIGN, MODE_EXP,
      MODE_WORD, MODE_LIT, MODE_LIT_QUOTE
   } mode_type;

   typedef struct packed {
      logic [5:0]             kind;
      logic [RESULT_BITS-1:0] start;
      logic [RESULT_BITS-1:0] len;
      logic [2:0]             err;
      logic [7:0]             ech;
      logic                   last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef logic [WORD_DEPTH-1:0][4:0] letters_type;
   typedef logic [8*WORD_DEPTH-1:0]    kw_text_type;

   localparam kw_text_type KW_TEXT [KW_COUNT] = '{
      "AND", "ARRAY", "BEGIN", "CASE", "CONST", "DIV", "DO", "DOWNTO",
      "ELSE", "END", "FILE", "FOR", "FUNCTION", "GOTO", "IF", "IN",
      "LABEL", "MOD", "NIL", "NOT", "OF", "OR", "PACKED", "PROCEDURE",
      "PROGRAM", "RECORD", "REPEAT", "SET", "THEN", "TO", "TYPE", "UNTIL",
      "VAR", "WHILE", "WITH"};

   localparam int KW_LEN [KW_COUNT] = '{
      3, 5, 5, 4, 5, 3, 2, 6, 4, 3, 4, 3, 8, 4, 2, 2, 5, 3, 3, 3, 2, 2, 6, 9,
      7, 6, 6, 3, 4, 2, 4, 5, 3, 5, 4};

   // Keyword kind of the collected word, or identifier.
   function automatic logic [5:0] word_kind(letters_type letters, logic [3:0] wlen);
      logic [5:0] kind;
      logic       same;
      int         idx;
      kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         same = (32'(wlen) == KW_LEN[k]);
         for (int j = 0; j < WORD_DEPTH; j++) begin
            idx = (j < KW_LEN[k]) ? KW_LEN[k] - 1 - j : 0;
            if (j < KW_LEN[k] &&
                letters[j] != 5'(KW_TEXT[k][8*idx +: 8] - 8'd64)) begin
               same = 1'b0;
            end
         end
         if (same) begin
            kind = KIND_FIRST_KW + 6'(k);
         end
      end
      return kind;
   endfunction

endpackage

>>> src/pst_scan.sv
// Scanner state and one-item step logic of the Pascal source tokenizer.
// Depends on pst_pkg.
module pst_scan import pst_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] ch,
   input  logic       end_marker,
   output push_type   push
);

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

   typedef struct packed {
      logic                   valid;
      logic                   fin;
      result_type             res;
      logic [5:0]             kind;
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] stop;
      logic                   wordish;
   } evt_type;

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, tb_ff, tb_in;
   logic [7:0]             held_ff, held_in;
   letters_type            letters_ff, letters_in;
   logic [3:0]             wlen_ff, wlen_in;
   logic [1:0]             lit_ff, lit_in;
   logic                   prev_ff, prev_in, sep_ff, sep_in, halted_ff, halted_in;

   function automatic result_type tok_res(logic [5:0] kind, logic [OFFSET_BITS-1:0] start,
                                          logic [OFFSET_BITS-1:0] stop);
      result_type             r;
      logic [OFFSET_BITS-1:0] diff;
      diff = (stop >= start) ? stop - start : '0;
      r.kind  = kind;
      r.start = RESULT_BITS'(start);
      r.len   = ((diff >> RESULT_BITS) != '0) ? {RESULT_BITS{1'b1}} : RESULT_BITS'(diff);
      r.err   = ERR_NONE;
      r.ech   = 8'd0;
      r.last  = 1'b0;
      return r;
   endfunction

   function automatic result_type err_res(logic [2:0] code, logic [OFFSET_BITS-1:0] at,
                                          logic [7:0] ech);
      result_type r;
      r.kind  = SYM_PLUS;
      r.start = RESULT_BITS'(at);
      r.len   = '0;
      r.err   = code;
      r.ech   = ech;
      r.last  = 1'b1;
      return r;
   endfunction

   function automatic evt_type mk_fin(result_type res);
      evt_type e;
      e = '0;
      e.valid = 1'b1;
      e.fin   = 1'b1;
      e.res   = res;
      return e;
   endfunction

   function automatic evt_type mk_tok(logic [5:0] kind, logic [OFFSET_BITS-1:0] start,
                                      logic [OFFSET_BITS-1:0] stop, logic wordish);
      evt_type e;
      e = '0;
      e.valid   = 1'b1;
      e.kind    = kind;
      e.start   = start;
      e.stop    = stop;
      e.wordish = wordish;
      return e;
   endfunction

   always_comb begin
      evt_type                ev [2];
      logic                   used, sep_set, is_dig, is_let, is_e, halt;
      logic [7:0]             up;
      logic [4:0]             code;
      logic [1:0]             n;
      result_type             r [2];
      logic [OFFSET_BITS-1:0] pos_inc, pos_dec, eof_at;
      result_type             eof_res;

      mode_in = mode_ff; pos_in = pos_ff; tb_in = tb_ff; held_in = held_ff;
      letters_in = letters_ff; wlen_in = wlen_ff; lit_in = lit_ff;
      prev_in = prev_ff; sep_in = sep_ff; halted_in = halted_ff;
      ev[0] = '0; ev[1] = '0; used = 1'b0; sep_set = 1'b0;
      r[0] = '0; r[1] = '0; n = 2'd0;

      up      = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      is_dig  = ch >= "0" && ch <= "9";
      is_let  = up >= "A" && up <= "Z";
      is_e    = up == "E";
      code    = is_dig ? DIGIT_CODE : 5'(up - 8'd64);
      pos_inc = pos_ff + 1'b1;
      pos_dec = pos_ff - 1'b1;
      eof_at  = pos_ff;
      eof_res = tok_res(KIND_EOF, eof_at, eof_at + 1'b1);
      eof_res.len  = RESULT_BITS'(1);
      eof_res.last = 1'b1;

      if (!end_marker) begin
         pos_in = pos_inc;
      end

      if (!end_marker && pos_ff == OFF_MAX) begin
         ev[0] = mk_fin(err_res(ERR_OVERFLOW, pos_ff, ch));
      end else begin
         case (mode_ff)
            MODE_COMMENT, MODE_COMMENT_STAR: begin
               if (end_marker) begin
                  ev[0] = mk_fin(err_res(ERR_OPEN_CMT, pos_ff, 8'd0));
               end else begin
                  used = 1'b1;
                  if (ch == "}" || (mode_ff == MODE_COMMENT_STAR && ch == ")")) begin
                     mode_in = MODE_IDLE;
                     sep_set = 1'b1;
                  end else begin
                     mode_in = (ch == "*") ? MODE_COMMENT_STAR : MODE_COMMENT;
                  end
               end
            end
            MODE_HELD: begin
               mode_in = MODE_IDLE;
               case (held_ff)
                  "+", "-": begin
                     if (!end_marker && is_dig) begin
                        mode_in = MODE_INT_S; used = 1'b1;
                     end else begin
                        ev[0] = mk_tok((held_ff == "+") ? SYM_PLUS : SYM_MINUS, tb_ff,
                                       tb_ff + 1'b1, 1'b0);
                     end
                  end
                  "<": begin
                     if (!end_marker && (ch == ">" || ch == "=")) begin
                        ev[0] = mk_tok((ch == ">") ? SYM_NE : SYM_LE, tb_ff, tb_ff + 2'd2, 1'b0);
                        used = 1'b1;
                     end else begin
                        ev[0] = mk_tok(SYM_LT, tb_ff, tb_ff + 1'b1, 1'b0);
                     end
                  end
                  ">": begin
                     if (!end_marker && ch == "=") begin
                        ev[0] = mk_tok(SYM_GE, tb_ff, tb_ff + 2'd2, 1'b0); used = 1'b1;
                     end else begin
                        ev[0] = mk_tok(SYM_GT, tb_ff, tb_ff + 1'b1, 1'b0);
                     end
                  end
                  ".": begin
                     if (!end_marker && (ch == ")" || ch == ".")) begin
                        ev[0] = mk_tok((ch == ")") ? SYM_RBRK : SYM_DOTDOT, tb_ff,
                                       tb_ff + 2'd2, 1'b0);
                        used = 1'b1;
                     end else begin
                        ev[0] = mk_tok(SYM_DOT, tb_ff, tb_ff + 1'b1, 1'b0);
                     end
                  end
                  ":": begin
                     if (!end_marker && ch == "=") begin
                        ev[0] = mk_tok(SYM_ASSIGN, tb_ff, tb_ff + 2'd2, 1'b0); used = 1'b1;
                     end else begin
                        ev[0] = mk_tok(SYM_COLON, tb_ff, tb_ff + 1'b1, 1'b0);
                     end
                  end
                  "(": begin
                     if (!end_marker && ch == "*") begin
                        mode_in = MODE_COMMENT_STAR; used = 1'b1;
                     end else if (!end_marker && ch == ".") begin
                        ev[0] = mk_tok(SYM_LBRK, tb_ff, tb_ff + 2'd2, 1'b0); used = 1'b1;
                     end else begin
                        ev[0] = mk_tok(SYM_LPAR, tb_ff, tb_ff + 1'b1, 1'b0);
                     end
                  end
                  default: used = 1'b0;
               endcase
            end
            MODE_INT_U, MODE_INT_S: begin
               if (!end_marker && is_dig) begin
                  used = 1'b1;
               end else if (!end_marker && ch == ".") begin
                  mode_in = (mode_ff == MODE_INT_U) ? MODE_DOT_U : MODE_DOT_S; used = 1'b1;
               end else if (!end_marker && is_e) begin
                  mode_in = MODE_EXP_START; used = 1'b1;
               end else begin
                  ev[0] = mk_tok(KIND_INT, tb_ff, pos_ff, mode_ff == MODE_INT_U);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_DOT_U, MODE_DOT_S: begin
               if (end_marker) begin
                  ev[0] = mk_fin(err_res(ERR_DIGIT, pos_ff, 8'd0));
               end else begin
                  used = 1'b1;
                  if (is_dig) begin
                     mode_in = MODE_FRAC;
                  end else if (ch == "." || ch == ")") begin
                     // integer ends before the dot; the dot pairs with this byte
                     ev[0] = mk_tok(KIND_INT, tb_ff, pos_dec, mode_ff == MODE_DOT_U);
                     ev[1] = mk_tok((ch == ".") ? SYM_DOTDOT : SYM_RBRK, pos_dec, pos_inc, 1'b0);
                     mode_in = MODE_IDLE;
                  end else begin
                     ev[0] = mk_fin(err_res(ERR_DIGIT, pos_ff, ch));
                  end
               end
            end
            MODE_FRAC, MODE_EXP: begin
               if (!end_marker && is_dig) begin
                  used = 1'b1;
               end else if (!end_marker && mode_ff == MODE_FRAC && is_e) begin
                  mode_in = MODE_EXP_START; used = 1'b1;
               end else begin
                  ev[0] = mk_tok(KIND_REAL, tb_ff, pos_ff, 1'b0);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_EXP_START, MODE_EXP_SIGN: begin
               if (end_marker) begin
                  ev[0] = mk_fin(err_res(ERR_DIGIT, pos_ff, 8'd0));
               end else begin
                  used = 1'b1;
                  if (is_dig) begin
                     mode_in = MODE_EXP;
                  end else if (mode_ff == MODE_EXP_START && (ch == "+" || ch == "-")) begin
                     mode_in = MODE_EXP_SIGN;
                  end else begin
                     ev[0] = mk_fin(err_res(ERR_DIGIT, pos_ff, ch));
                  end
               end
            end
            MODE_WORD: begin
               if (!end_marker && (is_let || is_dig)) begin
                  if (wlen_ff < 4'd9) begin
                     letters_in[wlen_ff] = code;
                  end
                  if (wlen_ff < 4'd10) begin
                     wlen_in = wlen_ff + 1'b1;
                  end
                  used = 1'b1;
               end else begin
                  ev[0] = mk_tok(word_kind(letters_ff, wlen_ff), tb_ff, pos_ff, 1'b1);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_LIT: begin
               if (end_marker) begin
                  ev[0] = mk_fin(err_res(ERR_STR_CHAR, pos_ff, 8'd0));
               end else begin
                  used = 1'b1;
                  if (ch == "'") begin
                     mode_in = MODE_LIT_QUOTE;
                  end else if (ch >= 8'd32 && ch <= 8'd126) begin
                     if (lit_ff < 2'd2) lit_in = lit_ff + 1'b1;
                  end else begin
                     ev[0] = mk_fin(err_res(ERR_STR_CHAR, pos_ff, ch));
                  end
               end
            end
            MODE_LIT_QUOTE: begin
               if (!end_marker && ch == "'") begin
                  if (lit_ff < 2'd2) lit_in = lit_ff + 1'b1;
                  mode_in = MODE_LIT; used = 1'b1;
               end else begin
                  ev[0] = mk_tok((lit_ff == 2'd1) ? KIND_CHAR : KIND_STRING, tb_ff, pos_ff, 1'b0);
                  mode_in = MODE_IDLE;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase

         // byte not taken by an open token: end of file or a fresh start
         if (!used) begin
            if (end_marker) begin
               ev[1] = mk_fin(eof_res);
            end else if (ch[7]) begin
               ev[1] = mk_fin(err_res(ERR_NON_ASCII, pos_ff, ch));
            end else if (ch == "{") begin
               mode_in = MODE_COMMENT;
            end else if (ch == " " || (ch >= 8'd9 && ch <= 8'd13)) begin
               sep_set = 1'b1;
            end else begin
               case (ch)
                  "*": ev[1] = mk_tok(SYM_STAR, pos_ff, pos_inc, 1'b0);
                  "/": ev[1] = mk_tok(SYM_SLASH, pos_ff, pos_inc, 1'b0);
                  "=": ev[1] = mk_tok(SYM_EQ, pos_ff, pos_inc, 1'b0);
                  "[": ev[1] = mk_tok(SYM_LBRK, pos_ff, pos_inc, 1'b0);
                  "]": ev[1] = mk_tok(SYM_RBRK, pos_ff, pos_inc, 1'b0);
                  ",": ev[1] = mk_tok(SYM_COMMA, pos_ff, pos_inc, 1'b0);
                  ";": ev[1] = mk_tok(SYM_SEMI, pos_ff, pos_inc, 1'b0);
                  "^", "@": ev[1] = mk_tok(SYM_ARROW, pos_ff, pos_inc, 1'b0);
                  ")": ev[1] = mk_tok(SYM_RPAR, pos_ff, pos_inc, 1'b0);
                  "+", "-", "<", ">", ".", ":", "(": begin
                     held_in = ch; tb_in = pos_ff; mode_in = MODE_HELD;
                  end
                  "'": begin
                     tb_in = pos_ff; lit_in = 2'd0; mode_in = MODE_LIT;
                  end
                  default: begin
                     if (is_dig) begin
                        tb_in = pos_ff; held_in = ch; mode_in = MODE_INT_U;
                     end else if (is_let) begin
                        tb_in = pos_ff; held_in = ch; letters_in[0] = code;
                        wlen_in = 4'd1; mode_in = MODE_WORD;
                     end else begin
                        ev[1] = mk_fin(err_res(ERR_BAD_START, pos_ff, ch));
                     end
                  end
               endcase
            end
         end
      end

      // settle events in order; the first final result stops the stream
      halt = halted_ff;
      for (int e = 0; e < 2; e++) begin
         if (ev[e].valid && !halt) begin
            if (ev[e].fin) begin
               r[n[0]] = ev[e].res; n = n + 1'b1; halt = 1'b1;
            end else if (ev[e].wordish && prev_in && !sep_in) begin
               r[n[0]] = err_res(ERR_NO_SEP, ev[e].start, held_ff);
               n = n + 1'b1; halt = 1'b1;
            end else begin
               r[n[0]] = tok_res(ev[e].kind, ev[e].start, ev[e].stop);
               n = n + 1'b1;
               prev_in = ev[e].wordish;
               sep_in = 1'b0;
            end
         end
      end
      if (sep_set) begin
         sep_in = 1'b1;
      end
      halted_in = halt;

      push.count  = (fire && !halted_ff) ? n : 2'd0;
      push.first  = r[0];
      push.second = r[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         tb_ff     <= '0;
         held_ff   <= 8'd0;
         wlen_ff   <= 4'd0;
         lit_ff    <= 2'd0;
         prev_ff   <= 1'b0;
         sep_ff    <= 1'b1;
         halted_ff <= 1'b0;
      end else if (fire && !halted_ff) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         tb_ff     <= tb_in;
         held_ff   <= held_in;
         wlen_ff   <= wlen_in;
         lit_ff    <= lit_in;
         prev_ff   <= prev_in;
         sep_ff    <= sep_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && !halted_ff) begin
         letters_ff <= letters_in;
      end
   end

endmodule

>>> src/pst_rsp_queue.sv
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on pst_pkg.
module pst_rsp_queue import pst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   input  logic       pop,
   output result_type head,
   output logic       head_valid,
   output logic       room
);

   result_type entry_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] count_ff;

   assign head       = entry_ff[rd_ff];
   assign head_valid = count_ff != 3'd0;
   // room for a pair of results, whatever leaves this cycle
   assign room       = count_ff <= 3'd2;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ff + 2'd1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wr_ff    <= wr_ff + push.count;
         rd_ff    <= rd_ff + 2'(pop);
         count_ff <= count_ff + 3'(push.count) - 3'(pop);
      end
   end

endmodule

>>> src/pascal_source_tokenizer_unit.sv
// Top level of the Pascal source tokenizer: input register, scanner, result queue.
// Depends on pst_pkg, pst_scan and pst_rsp_queue.
// Path: a source byte is registered on acceptance, stepped through the scanner once the
//   result queue has room, and its results are registered in the queue and offered on rsp_.
// Throughput: one byte per cycle while the queue has room for two results; a byte that closes two
//   tokens puts two results in the four-entry queue, which drains one per cycle on rsp_tready.
// Reset: synchronous, active high; clears scan state, offsets and queue pointers.
module pascal_source_tokenizer_unit import pst_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   // source byte item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_marker
   // token item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [23:0] token_start, [47:24] token_length,
                                    // [50:48] error_code, [58:51] error_char,
                                    // rest zero
   output logic [5:0]  rsp_tuser,   // [5:0] token_kind
   output logic        rsp_tlast    // last
);

   logic       in_vld_ff;
   logic [7:0] in_ch_ff;
   logic       in_end_ff;
   logic       fire, room;
   push_type   push;
   result_type head;

   // step the held byte only when the queue can absorb two results
   assign fire       = in_vld_ff && room;
   assign req_tready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_vld_ff <= 1'b1;
      end else if (fire) begin
         in_vld_ff <= 1'b0;
      end
   end

   // payload: hold while stalled
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff  <= req_tdata;
         in_end_ff <= req_tlast;
      end
   end

   pst_scan #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .ch         (in_ch_ff),
      .end_marker (in_end_ff),
      .push       (push)
   );

   pst_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tvalid && rsp_tready),
      .head       (head),
      .head_valid (rsp_tvalid),
      .room       (room)
   );

   assign rsp_tdata = {5'd0, head.ech, head.err, head.len, head.start};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // the scanner only produces results for a byte it actually steps
   a_push_only_on_fire: assert property (@(posedge clock) disable iff (reset)
      !fire |-> push.count == 2'd0)
      else $error("results pushed without a stepped byte");

   // the first of a pair is always an ordinary token
   a_pair_first_open: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.first.last)
      else $error("final result followed by another");

   // a pair is never pushed into a queue without room for it
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("result queue overfilled");

   // an error result carries zero length and closes the stream
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && head.err != ERR_NONE |-> head.len == '0 && rsp_tlast)
      else $error("malformed error result");

endmodule

>>> bench/pst_token_checker.sv
`timescale 1ns / 1ps
// Token checker for the Pascal source tokenizer: predicts tokens from the accepted
// source bytes and compares them with the result channel. Depends on pst_pkg.
module pst_token_checker import pst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [5:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          tokens_pending
);

   localparam logic [23:0] OFFSET_LAST = 24'hFFFFFF;

   string kw_words [KW_COUNT] = '{
      "AND", "ARRAY", "BEGIN", "CASE", "CONST", "DIV", "DO", "DOWNTO",
      "ELSE", "END", "FILE", "FOR", "FUNCTION", "GOTO", "IF", "IN",
      "LABEL", "MOD", "NIL", "NOT", "OF", "OR", "PACKED", "PROCEDURE",
      "PROGRAM", "RECORD", "REPEAT", "SET", "THEN", "TO", "TYPE", "UNTIL",
      "VAR", "WHILE", "WITH"};

   result_type  expected_tokens [$];

   mode_type    scan;
   logic [23:0] pos;
   logic [23:0] tok_begin;
   logic [7:0]  held;
   logic [4:0]  letters [WORD_DEPTH];
   logic [3:0]  wlen;
   logic [1:0]  lit_count;
   bit          prev_word;
   bit          sep_seen;
   bit          halted;

   function automatic bit digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [7:0] to_upper(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic bit letter_char(logic [7:0] c);
      return to_upper(c) >= "A" && to_upper(c) <= "Z";
   endfunction

   function automatic logic [5:0] lookup_word();
      bit same;
      if (wlen > 4'd9) return KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         same = (kw_words[k].len() == int'(wlen));
         for (int j = 0; j < int'(wlen) && same; j++) begin
            if (letters[j] != 5'(kw_words[k][j] - 8'd64)) same = 0;
         end
         if (same) return KIND_FIRST_KW + 6'(k);
      end
      return KIND_IDENT;
   endfunction

   task automatic push_token(logic [5:0] kind, logic [23:0] start, logic [23:0] len,
                             logic [2:0] err, logic [7:0] ech, logic last);
      result_type r;
      r.kind = kind; r.start = start; r.len = len;
      r.err = err; r.ech = ech; r.last = last;
      expected_tokens.push_back(r);
   endtask

   task automatic raise_err(logic [2:0] code, logic [23:0] at, logic [7:0] ech);
      if (halted) return;
      push_token(6'd0, at, 24'd0, code, ech, 1'b1);
      halted = 1;
   endtask

   task automatic emit_tok(logic [5:0] kind, logic [23:0] start, logic [23:0] stop,
                           bit wordish);
      if (halted) return;
      if (wordish && prev_word && !sep_seen) begin
         raise_err(ERR_NO_SEP, start, held);
         return;
      end
      push_token(kind, start, stop >= start ? stop - start : 24'd0, ERR_NONE, 8'd0, 1'b0);
      prev_word = wordish;
      sep_seen  = 0;
   endtask

   task automatic start_byte(logic [7:0] c, logic [23:0] p);
      if (c > 8'd127) begin
         raise_err(ERR_NON_ASCII, p, c);
         return;
      end
      if (c == "{") begin scan = MODE_COMMENT; return; end
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin sep_seen = 1; return; end
      case (c)
         "*": begin emit_tok(SYM_STAR, p, p + 1, 0); return; end
         "/": begin emit_tok(SYM_SLASH, p, p + 1, 0); return; end
         "=": begin emit_tok(SYM_EQ, p, p + 1, 0); return; end
         "[": begin emit_tok(SYM_LBRK, p, p + 1, 0); return; end
         "]": begin emit_tok(SYM_RBRK, p, p + 1, 0); return; end
         ",": begin emit_tok(SYM_COMMA, p, p + 1, 0); return; end
         ";": begin emit_tok(SYM_SEMI, p, p + 1, 0); return; end
         "^", "@": begin emit_tok(SYM_ARROW, p, p + 1, 0); return; end
         ")": begin emit_tok(SYM_RPAR, p, p + 1, 0); return; end
         "+", "-", "<", ">", ".", ":", "(": begin
            held = c; tok_begin = p; scan = MODE_HELD; return;
         end
         "'": begin tok_begin = p; lit_count = 0; scan = MODE_LIT; return; end
         default: ;
      endcase
      if (digit_char(c)) begin
         tok_begin = p; held = c; scan = MODE_INT_U; return;
      end
      if (letter_char(c)) begin
         tok_begin = p; held = c;
         letters[0] = 5'(to_upper(c) - 8'd64);
         wlen = 4'd1; scan = MODE_WORD; return;
      end
      raise_err(ERR_BAD_START, p, c);
   endtask

   // Settle a held symbol byte against the next byte; used is set if that byte is eaten.
   task automatic settle_held(logic [7:0] c, bit endm, output bit used);
      logic [5:0]  kind;
      logic [5:0]  pair;
      bit          paired;
      logic [23:0] b;
      b = tok_begin;
      paired = 0;
      pair = 6'd0;
      used = 0;
      scan = MODE_IDLE;
      case (held)
         "+", "-": begin
            if (!endm && digit_char(c)) begin scan = MODE_INT_S; used = 1; return; end
            kind = held == "+" ? SYM_PLUS : SYM_MINUS;
         end
         "<": begin
            if (!endm && c == ">") begin paired = 1; pair = SYM_NE; end
            else if (!endm && c == "=") begin paired = 1; pair = SYM_LE; end
            kind = SYM_LT;
         end
         ">": begin
            if (!endm && c == "=") begin paired = 1; pair = SYM_GE; end
            kind = SYM_GT;
         end
         ".": begin
            if (!endm && c == ")") begin paired = 1; pair = SYM_RBRK; end
            else if (!endm && c == ".") begin paired = 1; pair = SYM_DOTDOT; end
            kind = SYM_DOT;
         end
         ":": begin
            if (!endm && c == "=") begin paired = 1; pair = SYM_ASSIGN; end
            kind = SYM_COLON;
         end
         "(": begin
            if (!endm && c == "*") begin scan = MODE_COMMENT_STAR; used = 1; return; end
            if (!endm && c == ".") begin paired = 1; pair = SYM_LBRK; end
            kind = SYM_LPAR;
         end
         default: return;
      endcase
      if (paired) begin
         emit_tok(pair, b, b + 2, 0);
         used = 1;
      end else begin
         emit_tok(kind, b, b + 1, 0);
      end
   endtask

   // Advance the tokenizer state by one source item.
   task automatic scan_item(logic [7:0] c, bit endm);
      logic [23:0] p;
      bit          used;
      p = pos;
      used = 0;
      if (halted) return;
      if (!endm && p >= OFFSET_LAST) begin
         raise_err(ERR_OVERFLOW, p, c);
         return;
      end
      case (scan)
         MODE_COMMENT, MODE_COMMENT_STAR: begin
            if (endm) raise_err(ERR_OPEN_CMT, p, 8'd0);
            else begin
               used = 1;
               if (c == "}" || (scan == MODE_COMMENT_STAR && c == ")")) begin
                  scan = MODE_IDLE; sep_seen = 1;
               end else begin
                  scan = c == "*" ? MODE_COMMENT_STAR : MODE_COMMENT;
               end
            end
         end
         MODE_HELD: settle_held(c, endm, used);
         MODE_INT_U, MODE_INT_S: begin
            if (!endm && digit_char(c)) used = 1;
            else if (!endm && c == ".") begin
               scan = scan == MODE_INT_U ? MODE_DOT_U : MODE_DOT_S; used = 1;
            end else if (!endm && to_upper(c) == "E") begin
               scan = MODE_EXP_START; used = 1;
            end else begin
               emit_tok(KIND_INT, tok_begin, p, scan == MODE_INT_U);
               scan = MODE_IDLE;
            end
         end
         MODE_DOT_U, MODE_DOT_S: begin
            if (endm) raise_err(ERR_DIGIT, p, 8'd0);
            else begin
               used = 1;
               if (digit_char(c)) scan = MODE_FRAC;
               else if (c == "." || c == ")") begin
                  emit_tok(KIND_INT, tok_begin, p - 1, scan == MODE_DOT_U);
                  emit_tok(c == "." ? SYM_DOTDOT : SYM_RBRK, p - 1, p + 1, 0);
                  scan = MODE_IDLE;
               end else raise_err(ERR_DIGIT, p, c);
            end
         end
         MODE_FRAC, MODE_EXP: begin
            if (!endm && digit_char(c)) used = 1;
            else if (!endm && scan == MODE_FRAC && to_upper(c) == "E") begin
               scan = MODE_EXP_START; used = 1;
            end else begin
               emit_tok(KIND_REAL, tok_begin, p, 0);
               scan = MODE_IDLE;
            end
         end
         MODE_EXP_START, MODE_EXP_SIGN: begin
            if (endm) raise_err(ERR_DIGIT, p, 8'd0);
            else begin
               used = 1;
               if (digit_char(c)) scan = MODE_EXP;
               else if (scan == MODE_EXP_START && (c == "+" || c == "-"))
                  scan = MODE_EXP_SIGN;
               else raise_err(ERR_DIGIT, p, c);
            end
         end
         MODE_WORD: begin
            if (!endm && (letter_char(c) || digit_char(c))) begin
               if (wlen < 4'd9)
                  letters[wlen] = digit_char(c) ? DIGIT_CODE : 5'(to_upper(c) - 8'd64);
               if (wlen < 4'd10) wlen++;
               used = 1;
            end else begin
               emit_tok(lookup_word(), tok_begin, p, 1);
               scan = MODE_IDLE;
            end
         end
         MODE_LIT: begin
            if (endm) raise_err(ERR_STR_CHAR, p, 8'd0);
            else begin
               used = 1;
               if (c == "'") scan = MODE_LIT_QUOTE;
               else if (c >= 8'd32 && c <= 8'd126) begin
                  if (lit_count < 2'd2) lit_count++;
               end else raise_err(ERR_STR_CHAR, p, c);
            end
         end
         MODE_LIT_QUOTE: begin
            if (!endm && c == "'") begin
               if (lit_count < 2'd2) lit_count++;
               scan = MODE_LIT; used = 1;
            end else begin
               emit_tok(lit_count == 2'd1 ? KIND_CHAR : KIND_STRING, tok_begin, p, 0);
               scan = MODE_IDLE;
            end
         end
         default: scan = MODE_IDLE;
      endcase
      if (!used && !halted) begin
         if (endm) begin
            push_token(KIND_EOF, p, 24'd1, ERR_NONE, 8'd0, 1'b1);
            halted = 1;
         end else begin
            start_byte(c, p);
         end
      end
      if (!endm) pos = p + 1;
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         scan = MODE_IDLE; pos = '0; tok_begin = '0; held = '0;
         wlen = '0; lit_count = '0; prev_word = 0; sep_seen = 1; halted = 0;
         expected_tokens.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind  = rsp_tuser;
            got.start = rsp_tdata[23:0];
            got.len   = rsp_tdata[47:24];
            got.err   = rsp_tdata[50:48];
            got.ech   = rsp_tdata[58:51];
            got.last  = rsp_tlast;
            if (expected_tokens.size() == 0) begin
               $display("%0t: token with none expected: kind %0d start %0d len %0d err %0d",
                        $time, got.kind, got.start, got.len, got.err);
               fail_count++;
            end else begin
               want = expected_tokens.pop_front();
               if (got !== want) begin
                  $display("%0t: expected kind %0d start %0d len %0d err %0d ech %h last %b",
                           $time, want.kind, want.start, want.len, want.err, want.ech,
                           want.last);
                  $display("%0t: actual   kind %0d start %0d len %0d err %0d ech %h last %b",
                           $time, got.kind, got.start, got.len, got.err, got.ech, got.last);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) scan_item(req_tdata, req_tlast);
      end
      tokens_pending = expected_tokens.size();
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the tokenizer testbench: clock, reset, source text stimulus and verdict.
// Depends on pst_pkg, pascal_source_tokenizer_unit and pst_token_checker.
module tb_top;
   import pst_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TEXT_TARGET    = 1140;

   // token classes, used to decide where a separator is required
   typedef enum int {CLS_SYMBOL, CLS_WORD, CLS_NUMBER, CLS_LITERAL} token_class_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          tokens_pending;

   logic [7:0]  source_text [$];
   bit          calm;       // set during stretches with no idling on either side
   int          stall_left = 0;
   int          quiet_cycles = 0;

   pascal_source_tokenizer_unit DUT (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

   pst_token_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .fail_count, .tokens_pending
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // result side: random stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic add_text(string s);
      foreach (s[i]) source_text.push_back(s[i]);
   endtask

   function automatic logic [7:0] flip_case(logic [7:0] c);
      if ($urandom_range(0, 1) == 0) return c;
      if (c >= "A" && c <= "Z") return c + 8'd32;
      if (c >= "a" && c <= "z") return c - 8'd32;
      return c;
   endfunction

   function automatic logic [7:0] rand_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 26) return 8'("A" + r);
      if (r < 52) return 8'("a" + r - 26);
      return 8'("0" + r - 52);
   endfunction

   function automatic string rand_digits(int lo, int hi);
      string s;
      int    n;
      s = "";
      n = $urandom_range(lo, hi);
      for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
      return s;
   endfunction

   // comment body: any nonzero byte but the closers' characters
   function automatic string rand_comment_body();
      string       s;
      logic [7:0]  c;
      int          n;
      s = "";
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
         do c = 8'($urandom_range(1, 255)); while (c == "}" || c == "*" || c == ")");
         s = {s, string'(c)};
      end
      return s;
   endfunction

   function automatic string rand_separator();
      case ($urandom_range(0, 9))
         0:       return {"{", rand_comment_body(), "}"};
         1:       return {"(*", rand_comment_body(),
                          $urandom_range(0, 1) ? string'("*)") : string'("}")};
         2:       return "(*)";
         3:       return string'(8'($urandom_range(9, 13)));
         default: return " ";
      endcase
   endfunction

   task automatic rand_token(output string tok, output token_class_type cls);
      string syms [24] = '{"+", "-", "*", "/", "=", "<", ">", "[", "]", ".", ",", ":",
                           ";", "^", "@", "(", ")", "<>", "<=", ">=", ":=", "..", "(.",
                           ".)"};
      int k;
      int n;
      logic [7:0] c;
      tok = "";
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            tok = syms[$urandom_range(0, 23)];
            cls = CLS_SYMBOL;
         end
         3, 4: begin
            k = $urandom_range(0, KW_COUNT - 1);
            for (int j = 0; j < KW_LEN[k]; j++)
               tok = {tok, string'(flip_case(KW_TEXT[k][8 * (KW_LEN[k] - 1 - j) +: 8]))};
            if ($urandom_range(0, 4) == 0) tok = {tok, string'(rand_alnum())};
            cls = CLS_WORD;
         end
         5, 6: begin
            tok = string'(flip_case(8'("A" + $urandom_range(0, 25))));
            n = $urandom_range(0, 11);
            for (int j = 0; j < n; j++) tok = {tok, string'(rand_alnum())};
            cls = CLS_WORD;
         end
         7: begin
            tok = rand_digits(1, 8);
            cls = CLS_NUMBER;
         end
         8: begin
            tok = {$urandom_range(0, 1) ? "+" : "-", rand_digits(1, 4)};
            cls = CLS_NUMBER;
         end
         9: begin
            tok = rand_digits(1, 3);
            if ($urandom_range(0, 1)) tok = {tok, ".", rand_digits(1, 3)};
            if ($urandom_range(0, 1))
               tok = {tok, $urandom_range(0, 1) ? "E" : "e",
                      $urandom_range(0, 2) == 0 ? string'("") :
                      ($urandom_range(0, 1) ? string'("+") : string'("-")),
                      rand_digits(1, 2)};
            else if ($urandom_range(0, 1)) tok = {"-", tok, ".5"};
            cls = CLS_NUMBER;
         end
         default: begin
            tok = "'";
            n = $urandom_range(0, 4);
            for (int j = 0; j < n; j++) begin
               c = 8'($urandom_range(32, 126));
               tok = {tok, string'(c)};
               if (c == "'") tok = {tok, "'"};
            end
            tok = {tok, "'"};
            cls = CLS_LITERAL;
         end
      endcase
   endtask

   task automatic send_item(logic [7:0] c, bit endm);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= endm;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      string           tok;
      string           prev_tok;
      token_class_type cls;
      token_class_type prev_cls;
      bit              need_sep;
      int              half;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      req_tlast  = 1'b0;
      calm       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed text: most symbol forms, both comment forms with mixed closers,
      // signed and real numbers, integers before '..' and '.)', empty and doubled
      // quote literals, long words and keyword look-alikes
      add_text("PROGRAM p(output);{c}(*c*)(*)x:=-5+3.14e-2*7E+2/1;a[1..9]<>b(.2.)^@<=>=.");
      add_text("'q''' '' 'ab' procedure downto Procedurex abcdefghij {a*)(*b}+ x - y<z>");
      add_text("w,v {");
      source_text.push_back(8'hFF);   // high byte, legal only inside a comment
      add_text("} ");

      // random tokens, separated wherever adjacency would merge or break them
      prev_cls = CLS_SYMBOL;
      prev_tok = "";
      while (source_text.size() < TEXT_TARGET) begin
         rand_token(tok, cls);
         need_sep = !(prev_cls == CLS_SYMBOL || (prev_cls == CLS_WORD && cls == CLS_SYMBOL));
         if (prev_tok == "(" && tok.substr(0, 0) == "*") need_sep = 1;
         if (need_sep || $urandom_range(0, 3) == 0) add_text(rand_separator());
         add_text(tok);
         prev_tok = tok;
         prev_cls = cls;
      end

      // close the stream with one ending: clean end of file or one kind of error
      add_text(" ");
      case ($urandom_range(0, 8))
         2: source_text.push_back(8'($urandom_range(128, 255)));
         3: add_text("{ab");
         4: begin
            tok = "!\"#$%&?_`|~}";
            source_text.push_back(tok[$urandom_range(0, tok.len() - 1)]);
         end
         5: add_text($urandom_range(0, 1) ? "3.;" : "2E");
         6: begin
            add_text("'a");
            source_text.push_back(8'($urandom_range(0, 31)));
         end
         7: add_text("'abc");
         8: add_text("12abc ");
         default: ;
      endcase

      half = source_text.size() / 2;
      foreach (source_text[i]) begin
         if ($urandom_range(0, 199) == 0) calm = !calm;
         if (i == half) begin
            // hold the source until every token so far has come out
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (tokens_pending != 0) @(posedge clock);
         end
         send_item(source_text[i], 1'b0);
      end
      calm = 1'b0;
      send_item(8'($urandom), 1'b1);
      // after the end the block stays quiet; feed a few stray items
      repeat (3) send_item(8'($urandom), $urandom_range(0, 1));
      req_tvalid <= 1'b0;

      while (tokens_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
